>>> hdl/keyboard_matrix_layer_mapper_defines.svh
`ifndef KEYBOARD_MATRIX_LAYER_MAPPER_DEFINES_SVH
`define KEYBOARD_MATRIX_LAYER_MAPPER_DEFINES_SVH

// concurrent check, masked while reset is low
`define KMLM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// concurrent check that also runs through reset
`define KMLM_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/kmlm_pkg.sv
`timescale 1ns / 1ps
package kmlm_pkg;

  // input item kinds
  localparam logic [1:0] FUNC_LOCAL  = 2'd0;
  localparam logic [1:0] FUNC_REMOTE = 2'd1;
  localparam logic [1:0] FUNC_MAP    = 2'd2;

  // result kinds
  localparam logic [1:0] EV_PRESS   = 2'd0;
  localparam logic [1:0] EV_RELEASE = 2'd1;
  localparam logic [1:0] EV_LAYER   = 2'd2;

  // register indexes and reset values
  localparam logic       REG_BASE   = 1'b0;
  localparam logic       REG_ALT    = 1'b1;
  localparam logic [7:0] BASE_RESET = 8'hF0;
  localparam logic [7:0] ALT_RESET  = 8'hF1;
  localparam int         CFG_AW     = 3;
  localparam int         CFG_DW     = 32;

  localparam logic [7:0] LAYER_KEY_MIN     = 8'hF0;
  localparam int         REPORT_IGNORE_BIT = 7;
  localparam int         REPORT_PRESS_BIT  = 6;
  localparam int         REPORT_IDX_W      = 6;

  localparam int OUT_DEPTH = 4;
  localparam int OUT_PW    = $clog2(OUT_DEPTH);
  localparam int OUT_CW    = $clog2(OUT_DEPTH + 1);

  typedef struct packed {
    logic       v;
    logic [1:0] kind;
    logic [7:0] code;
  } ev_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] code;
    logic       last;
  } word_t;

  typedef struct packed {
    logic  v0;
    logic  v1;
    word_t w0;
    word_t w1;
  } push_t;

endpackage

>>> hdl/kmlm_ram.sv
`timescale 1ns / 1ps
module kmlm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_a_r;
  logic [WIDTH-1:0] rdata_b_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_a_r <= mem_r[raddr_a];
      rdata_b_r <= mem_r[raddr_b];
    end
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule

>>> hdl/kmlm_remote_addr.sv
`timescale 1ns / 1ps
module kmlm_remote_addr
  import kmlm_pkg::*;
#(
  parameter int ROWS        = 4,
  parameter int LOCAL_COLS  = 8,
  parameter int REMOTE_COLS = 8,
  parameter int REMOTE_ROWS = 4
) (
  input  logic [REPORT_IDX_W-1:0]                                idx,
  input  logic                                                   layer,
  output logic                                                   in_matrix,
  output logic [$clog2(2*ROWS*(LOCAL_COLS+REMOTE_COLS))-1:0]     addr
);

  localparam int ALL_COLS   = LOCAL_COLS + REMOTE_COLS;
  localparam int LAYER_SIZE = ROWS * ALL_COLS;
  localparam int MAP_AW     = $clog2(2 * LAYER_SIZE);
  localparam int MROWS      = (REMOTE_ROWS < ROWS) ? REMOTE_ROWS : ROWS;
  localparam int LIMIT      = MROWS * REMOTE_COLS;

  logic [2:0]              r;
  logic [REPORT_IDX_W-1:0] col;

  assign in_matrix = (7'(idx) < 7'(LIMIT));

  // row by threshold compares against multiples of the column count
  always_comb begin
    r = 3'd0;
    for (int k = 1; k < 8; k++) begin
      if (k < MROWS && 7'(idx) >= 7'(k * REMOTE_COLS)) begin
        r = r + 3'd1;
      end
    end
  end

  assign col = idx - REPORT_IDX_W'(r) * REPORT_IDX_W'(REMOTE_COLS);

  assign addr = in_matrix ?
      (MAP_AW'(layer) * MAP_AW'(LAYER_SIZE) + MAP_AW'(r) * MAP_AW'(ALL_COLS)
       + MAP_AW'(LOCAL_COLS) + MAP_AW'(col)) : '0;

endmodule

>>> hdl/kmlm_out_fifo.sv
`timescale 1ns / 1ps
module kmlm_out_fifo
  import kmlm_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  push_t push,
  output logic  room,
  output logic  out_valid,
  input  logic  out_ready,
  output word_t out_word
);

  word_t             mem_r [OUT_DEPTH];
  logic [OUT_PW-1:0] wr_ptr_r;
  logic [OUT_PW-1:0] rd_ptr_r;
  logic [OUT_CW-1:0] cnt_r;
  logic [OUT_CW-1:0] cnt_nxt;
  logic [OUT_PW-1:0] n_push;
  logic              pop;

  assign pop       = out_valid && out_ready;
  assign n_push    = OUT_PW'(push.v0) + OUT_PW'(push.v1);
  assign cnt_nxt   = cnt_r + OUT_CW'(n_push) - OUT_CW'(pop);
  assign out_valid = (cnt_r != '0);
  assign out_word  = mem_r[rd_ptr_r];
  assign room      = (cnt_r <= OUT_CW'(OUT_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + n_push;
      rd_ptr_r <= rd_ptr_r + OUT_PW'(pop);
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.v0) begin
      mem_r[wr_ptr_r] <= push.w0;
    end
    if (push.v1) begin
      mem_r[wr_ptr_r + OUT_PW'(1)] <= push.w1;
    end
  end

endmodule

>>> hdl/keyboard_matrix_layer_mapper.sv
`timescale 1ns / 1ps
// path: stage 1 and stage 2 registers, then the output queue
// throughput: one input word per cycle while the queue has room; the single output
//   port gives at most one result word per cycle; two-result words slow the input
// reset: synchronous active low; clears pipeline, output queue, key levels (released),
//   remote key, layer, pending code; presets layer code registers; keymap is not cleared
module keyboard_matrix_layer_mapper
  import kmlm_pkg::*;
#(
  parameter int ROWS        = 4,
  parameter int LOCAL_COLS  = 8,
  parameter int REMOTE_COLS = 8,
  parameter int REMOTE_ROWS = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_func,
  input  logic [2:0]        in_row,
  input  logic [3:0]        in_column,
  input  logic              in_level,
  input  logic              in_end_of_scan,
  input  logic [7:0]        in_report_byte,
  input  logic              in_map_layer,
  input  logic [7:0]        in_map_code,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_event_kind,
  output logic [7:0]        out_key_code,
  output logic              out_last
);

  localparam int ALL_COLS   = LOCAL_COLS + REMOTE_COLS;
  localparam int LAYER_SIZE = ROWS * ALL_COLS;
  localparam int MAP_DEPTH  = 2 * LAYER_SIZE;
  localparam int MAP_AW     = $clog2(MAP_DEPTH);
  localparam int NLOC       = ROWS * LOCAL_COLS;
  localparam int LW         = (NLOC > 1) ? $clog2(NLOC) : 1;

  function automatic ev_t key_change(input logic pressed, input logic [7:0] code);
    ev_t e;
    e.code = code;
    e.v    = pressed || (code < LAYER_KEY_MIN);
    if (!pressed) begin
      e.kind = EV_RELEASE;
    end else if (code >= LAYER_KEY_MIN) begin
      e.kind = EV_LAYER;
    end else begin
      e.kind = EV_PRESS;
    end
    return e;
  endfunction

  // configuration
  logic [7:0] base_code_r;
  logic [7:0] alt_code_r;
  logic       cfg_wr;

  // stage 1
  logic       s1_v_r;
  logic [1:0] s1_func_r;
  logic [2:0] s1_row_r;
  logic [3:0] s1_col_r;
  logic       s1_level_r;
  logic       s1_eos_r;
  logic [7:0] s1_rb_r;
  logic       s1_mlayer_r;
  logic [7:0] s1_mcode_r;

  // stage 2
  logic       s2_v_r;
  logic [1:0] s2_func_r;
  logic [2:0] s2_row_r;
  logic [3:0] s2_col_r;
  logic       s2_level_r;
  logic       s2_eos_r;
  logic [7:0] s2_rb_r;
  logic       s2_loc_ok_r;
  logic       s2_new_ok_r;

  // key state
  logic [NLOC-1:0]         levels_r;
  logic [NLOC-1:0]         levels_nxt;
  logic                    rem_v_r;
  logic                    rem_v_nxt;
  logic [REPORT_IDX_W-1:0] rem_idx_r;
  logic [REPORT_IDX_W-1:0] rem_idx_nxt;
  logic                    layer_r;
  logic                    layer_nxt;
  logic                    pend_v_r;
  logic                    pend_v_nxt;
  logic [7:0]              pend_code_r;
  logic [7:0]              pend_code_nxt;

  logic in_accept;
  logic room;
  logic s2_fire;
  logic s2_take;

  logic              row_ok;
  logic              col_loc_ok;
  logic              col_all_ok;
  logic              loc_ok;
  logic [MAP_AW-1:0] loc_addr;
  logic [MAP_AW-1:0] map_addr;
  logic [MAP_AW-1:0] new_addr;
  logic [MAP_AW-1:0] old_addr;
  logic [MAP_AW-1:0] raddr_a;
  logic              new_ok;
  logic              old_ok;
  logic              map_we;
  logic [7:0]        rd_a;
  logic [7:0]        rd_b;

  logic [LW-1:0]           pos;
  logic                    change;
  logic [REPORT_IDX_W-1:0] idx;
  logic                    nv;
  logic                    rel;
  logic                    prs;
  ev_t                     ev_a;
  ev_t                     ev_b;
  logic                    press_layer;
  logic                    apply;
  logic                    pv1;
  logic [7:0]              pc1;
  push_t                   push;
  word_t                   head;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = {24'b0, (paddr[2] == REG_ALT) ? alt_code_r : base_code_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_code_r <= BASE_RESET;
      alt_code_r  <= ALT_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_BASE: base_code_r <= pwdata[7:0];
        REG_ALT:  alt_code_r  <= pwdata[7:0];
        default:  ;
      endcase
    end
  end

  // pipeline control
  assign s2_fire   = s2_v_r && room;
  assign s2_take   = s1_v_r && (!s2_v_r || s2_fire);
  assign in_ready  = !s1_v_r || s2_take;
  assign in_accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      if (in_accept) begin
        s1_v_r <= 1'b1;
      end else if (s2_take) begin
        s1_v_r <= 1'b0;
      end
      if (s2_take) begin
        s2_v_r <= 1'b1;
      end else if (s2_fire) begin
        s2_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_func_r   <= in_func;
      s1_row_r    <= in_row;
      s1_col_r    <= in_column;
      s1_level_r  <= in_level;
      s1_eos_r    <= in_end_of_scan;
      s1_rb_r     <= in_report_byte;
      s1_mlayer_r <= in_map_layer;
      s1_mcode_r  <= in_map_code;
    end
    if (s2_take) begin
      s2_func_r   <= s1_func_r;
      s2_row_r    <= s1_row_r;
      s2_col_r    <= s1_col_r;
      s2_level_r  <= s1_level_r;
      s2_eos_r    <= s1_eos_r;
      s2_rb_r     <= s1_rb_r;
      s2_loc_ok_r <= loc_ok;
      s2_new_ok_r <= new_ok;
    end
  end

  // stage 1: keymap addresses, using layer and remote key as left by stage 2
  assign row_ok     = ({1'b0, s1_row_r} < 4'(ROWS));
  assign col_loc_ok = ({1'b0, s1_col_r} < 5'(LOCAL_COLS));
  assign col_all_ok = ({1'b0, s1_col_r} < 5'(ALL_COLS));
  assign loc_ok     = row_ok && col_loc_ok;

  assign loc_addr = loc_ok ?
      (MAP_AW'(layer_nxt) * MAP_AW'(LAYER_SIZE) + MAP_AW'(s1_row_r) * MAP_AW'(ALL_COLS)
       + MAP_AW'(s1_col_r)) : '0;
  assign map_addr = MAP_AW'(s1_mlayer_r) * MAP_AW'(LAYER_SIZE)
      + MAP_AW'(s1_row_r) * MAP_AW'(ALL_COLS) + MAP_AW'(s1_col_r);
  assign map_we   = s2_take && (s1_func_r == FUNC_MAP) && row_ok && col_all_ok;
  assign raddr_a  = (s1_func_r == FUNC_REMOTE) ? new_addr : loc_addr;

  kmlm_remote_addr #(
    .ROWS        (ROWS),
    .LOCAL_COLS  (LOCAL_COLS),
    .REMOTE_COLS (REMOTE_COLS),
    .REMOTE_ROWS (REMOTE_ROWS)
  ) u_new_addr (
    .idx       (s1_rb_r[REPORT_IDX_W-1:0]),
    .layer     (layer_nxt),
    .in_matrix (new_ok),
    .addr      (new_addr)
  );

  kmlm_remote_addr #(
    .ROWS        (ROWS),
    .LOCAL_COLS  (LOCAL_COLS),
    .REMOTE_COLS (REMOTE_COLS),
    .REMOTE_ROWS (REMOTE_ROWS)
  ) u_old_addr (
    .idx       (rem_idx_nxt),
    .layer     (layer_nxt),
    .in_matrix (old_ok),
    .addr      (old_addr)
  );

  kmlm_ram #(
    .WIDTH (8),
    .DEPTH (MAP_DEPTH)
  ) u_keymap (
    .clk     (clk),
    .we      (map_we),
    .waddr   (map_addr),
    .wdata   (s1_mcode_r),
    .re      (s2_take),
    .raddr_a (raddr_a),
    .raddr_b (old_ok ? old_addr : '0),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  // stage 2: events and state update
  assign pos    = LW'(s2_row_r) * LW'(LOCAL_COLS) + LW'(s2_col_r);
  assign change = s2_loc_ok_r && (levels_r[pos] != s2_level_r);
  assign idx    = s2_rb_r[REPORT_IDX_W-1:0];
  assign nv     = s2_rb_r[REPORT_PRESS_BIT] && s2_new_ok_r;
  assign rel    = rem_v_r && (!nv || rem_idx_r != idx);
  assign prs    = nv && (!rem_v_r || rem_idx_r != idx);

  always_comb begin
    ev_a        = '0;
    ev_b        = '0;
    press_layer = 1'b0;
    apply       = 1'b0;
    levels_nxt  = levels_r;
    rem_v_nxt   = rem_v_r;
    rem_idx_nxt = rem_idx_r;
    if (s2_fire) begin
      case (s2_func_r)
        FUNC_LOCAL: begin
          if (change) begin
            levels_nxt[pos] = s2_level_r;
            ev_a            = key_change(!s2_level_r, rd_a);
            press_layer     = !s2_level_r && (rd_a >= LAYER_KEY_MIN);
          end
          apply = s2_eos_r;
        end
        FUNC_REMOTE: begin
          if (!s2_rb_r[REPORT_IGNORE_BIT]) begin
            if (rel && prs && idx < rem_idx_r) begin
              ev_a = key_change(1'b1, rd_a);
              ev_b = key_change(1'b0, rd_b);
            end else begin
              if (rel) begin
                ev_a = key_change(1'b0, rd_b);
              end
              if (prs) begin
                ev_b = key_change(1'b1, rd_a);
              end
            end
            press_layer = prs && (rd_a >= LAYER_KEY_MIN);
            rem_v_nxt   = nv;
            if (nv) begin
              rem_idx_nxt = idx;
            end
            apply = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // layer key bookkeeping
  assign pv1           = pend_v_r || press_layer;
  assign pc1           = press_layer ? rd_a : pend_code_r;
  assign pend_v_nxt    = apply ? 1'b0 : pv1;
  assign pend_code_nxt = pc1;

  always_comb begin
    layer_nxt = layer_r;
    if (apply && pv1) begin
      if (pc1 == base_code_r) begin
        layer_nxt = 1'b0;
      end else if (pc1 == alt_code_r) begin
        layer_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      levels_r    <= '1;
      rem_v_r     <= 1'b0;
      rem_idx_r   <= '0;
      layer_r     <= 1'b0;
      pend_v_r    <= 1'b0;
      pend_code_r <= '0;
    end else begin
      levels_r    <= levels_nxt;
      rem_v_r     <= rem_v_nxt;
      rem_idx_r   <= rem_idx_nxt;
      layer_r     <= layer_nxt;
      pend_v_r    <= pend_v_nxt;
      pend_code_r <= pend_code_nxt;
    end
  end

  // pack up to two result words, first in order goes first
  always_comb begin
    push.v0      = ev_a.v || ev_b.v;
    push.v1      = ev_a.v && ev_b.v;
    push.w0.kind = ev_a.v ? ev_a.kind : ev_b.kind;
    push.w0.code = ev_a.v ? ev_a.code : ev_b.code;
    push.w0.last = !push.v1;
    push.w1.kind = ev_b.kind;
    push.w1.code = ev_b.code;
    push.w1.last = 1'b1;
  end

  kmlm_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (head)
  );

  assign out_event_kind = head.kind;
  assign out_key_code   = head.code;
  assign out_last       = head.last;

endmodule

>>> hdl/kmlm_chk.sv
`timescale 1ns / 1ps
`include "keyboard_matrix_layer_mapper_defines.svh"
module kmlm_chk
  import kmlm_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_event_kind,
  input logic [7:0] out_key_code,
  input logic       out_last
);

  `KMLM_ASSERT_ALWAYS(a_reset_clears, !rst_n |=> (!out_valid && in_ready), "reset left words")
  `KMLM_ASSERT(a_out_hold, (out_valid && !out_ready) |=> out_valid, "output word dropped")
  `KMLM_ASSERT(a_last_follows, (out_valid && out_ready && !out_last) |=> (out_valid && out_last), "second word missing")
  `KMLM_ASSERT(a_layer_code, (out_valid && out_event_kind == EV_LAYER) |-> (out_key_code >= LAYER_KEY_MIN), "layer word with plain code")
  `KMLM_ASSERT(a_release_code, (out_valid && out_event_kind == EV_RELEASE) |-> (out_key_code < LAYER_KEY_MIN), "release of layer key")

endmodule

bind keyboard_matrix_layer_mapper kmlm_chk u_kmlm_chk (.*);

>>> verif/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import kmlm_pkg::*;

  localparam int ROWS        = 4;
  localparam int LOCAL_COLS  = 8;
  localparam int REMOTE_COLS = 8;
  localparam int REMOTE_ROWS = 4;
  localparam int ALL_COLS    = LOCAL_COLS + REMOTE_COLS;
  localparam int LAYER_SIZE  = ROWS * ALL_COLS;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam logic       PRESSED     = 1'b0;
  localparam logic       RELEASED    = 1'b1;
  localparam int         CYCLE_LIMIT = 200000;
  localparam int         SETTLE      = 8;
  localparam int         DIR_ROWS    = 25;
  localparam int         PHASE_WORDS = 100;

  typedef struct packed {
    logic [1:0] func;
    logic [2:0] row;
    logic [3:0] column;
    logic       level;
    logic       end_of_scan;
    logic [7:0] report_byte;
    logic       map_layer;
    logic [7:0] map_code;
  } stim_t;

  localparam int STIM_W = $bits(stim_t);

  typedef struct packed {
    stim_t      s;
    logic       typed;
    logic [1:0] n;
    word_t      r0;
    word_t      r1;
  } dir_row_t;

  logic              clk;
  logic              rst_n = 1'b0;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [CFG_DW-1:0] pwdata = '0;
  logic [CFG_DW-1:0] prdata;
  logic              pready;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [1:0]        in_func = '0;
  logic [2:0]        in_row = '0;
  logic [3:0]        in_column = '0;
  logic              in_level = 1'b1;
  logic              in_end_of_scan = 1'b0;
  logic [7:0]        in_report_byte = '0;
  logic              in_map_layer = 1'b0;
  logic [7:0]        in_map_code = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [1:0]        out_event_kind;
  logic [7:0]        out_key_code;
  logic              out_last;

  int unsigned cycles = 0;
  int          mismatches = 0;
  int          src_idle = 0;
  int          snk_idle = 0;

  // mirror of the mapper state
  logic [7:0] base_code;
  logic [7:0] alt_code;
  logic       level_mem [0:ROWS*LOCAL_COLS-1];
  logic       remote_valid;
  logic [5:0] remote_idx;
  logic [7:0] keymap [0:2*LAYER_SIZE-1];
  logic       layer_sel;
  logic       pend_valid;
  logic [7:0] pend_code;
  word_t      step_w [0:1];
  int         step_n;

  word_t      expected_events [$];
  word_t      want_w;
  dir_row_t   dir_tab [0:DIR_ROWS-1];

  keyboard_matrix_layer_mapper u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_func        (in_func),
    .in_row         (in_row),
    .in_column      (in_column),
    .in_level       (in_level),
    .in_end_of_scan (in_end_of_scan),
    .in_report_byte (in_report_byte),
    .in_map_layer   (in_map_layer),
    .in_map_code    (in_map_code),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_event_kind (out_event_kind),
    .out_key_code   (out_key_code),
    .out_last       (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic report_mismatch(input string field, input int got, input int want);
    mismatches++;
    $display("mismatch at cycle %0d: %s got %0h expected %0h", cycles, field, got, want);
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= snk_idle);
    if (rst_n && out_valid && out_ready) begin
      if (expected_events.size() == 0) begin
        report_mismatch("word with none pending, key_code", int'(out_key_code), 0);
      end else begin
        want_w = expected_events.pop_front();
        if (out_event_kind !== want_w.kind)
          report_mismatch("event_kind", int'(out_event_kind), int'(want_w.kind));
        if (out_key_code !== want_w.code)
          report_mismatch("key_code", int'(out_key_code), int'(want_w.code));
        if (out_last !== want_w.last)
          report_mismatch("last", int'(out_last), int'(want_w.last));
      end
    end
  end

  function automatic logic [7:0] mapped_code(input int r, input int c);
    return keymap[int'(layer_sel) * LAYER_SIZE + r * ALL_COLS + c];
  endfunction

  function automatic logic [7:0] remote_key(input logic [5:0] idx);
    return mapped_code(int'(idx) / REMOTE_COLS, LOCAL_COLS + int'(idx) % REMOTE_COLS);
  endfunction

  function automatic void add_event(input logic [1:0] kind, input logic [7:0] code);
    step_w[step_n] = {kind, code, 1'b0};
    step_n++;
  endfunction

  function automatic void key_change(input logic pressed, input logic [7:0] code);
    if (pressed) begin
      if (code >= LAYER_KEY_MIN) begin
        pend_valid = 1'b1;
        pend_code = code;
        add_event(EV_LAYER, code);
      end else begin
        add_event(EV_PRESS, code);
      end
    end else if (code < LAYER_KEY_MIN) begin
      add_event(EV_RELEASE, code);
    end
  endfunction

  function automatic void take_pending();
    if (pend_valid) begin
      if (pend_code == base_code) layer_sel = 1'b0;
      else if (pend_code == alt_code) layer_sel = 1'b1;
    end
    pend_valid = 1'b0;
  endfunction

  // advances the mirror by one word and, if keep is set, queues the events it causes
  function automatic void predict_events(input stim_t s, input logic keep);
    int         pos;
    int         idx_row;
    logic [5:0] idx;
    logic [5:0] oidx;
    logic       nv;
    logic       rel;
    logic       prs;
    step_n = 0;
    case (s.func)
      FUNC_LOCAL: begin
        if (s.row < ROWS && s.column < LOCAL_COLS) begin
          pos = int'(s.row) * LOCAL_COLS + int'(s.column);
          if (level_mem[pos] != s.level) begin
            level_mem[pos] = s.level;
            key_change(s.level == PRESSED, mapped_code(int'(s.row), int'(s.column)));
          end
        end
        if (s.end_of_scan) take_pending();
      end
      FUNC_REMOTE: begin
        if (!s.report_byte[REPORT_IGNORE_BIT]) begin
          idx = s.report_byte[REPORT_IDX_W-1:0];
          idx_row = int'(idx) / REMOTE_COLS;
          nv = s.report_byte[REPORT_PRESS_BIT] && idx_row < REMOTE_ROWS && idx_row < ROWS;
          oidx = remote_idx;
          rel = remote_valid && (!nv || oidx != idx);
          prs = nv && (!remote_valid || oidx != idx);
          if (rel && prs && idx < oidx) begin
            key_change(1'b1, remote_key(idx));
            key_change(1'b0, remote_key(oidx));
          end else begin
            if (rel) key_change(1'b0, remote_key(oidx));
            if (prs) key_change(1'b1, remote_key(idx));
          end
          remote_valid = nv;
          if (nv) remote_idx = idx;
          take_pending();
        end
      end
      FUNC_MAP: begin
        if (s.row < ROWS && s.column < ALL_COLS)
          keymap[int'(s.map_layer) * LAYER_SIZE + int'(s.row) * ALL_COLS + int'(s.column)] =
            s.map_code;
      end
      default: ;
    endcase
    if (step_n > 0) step_w[step_n-1][0] = 1'b1;
    if (keep) begin
      for (int i = 0; i < step_n; i++) expected_events.push_back(step_w[i]);
    end
  endfunction

  function automatic stim_t loc(input int r, input int c, input logic lvl, input logic eos);
    stim_t s;
    s = '0;
    s.func = FUNC_LOCAL;
    s.row = 3'(r);
    s.column = 4'(c);
    s.level = lvl;
    s.end_of_scan = eos;
    return s;
  endfunction

  function automatic stim_t rep(input logic [7:0] b);
    stim_t s;
    s = '0;
    s.func = FUNC_REMOTE;
    s.report_byte = b;
    return s;
  endfunction

  function automatic stim_t kmap(input logic l, input int r, input int c, input logic [7:0] code);
    stim_t s;
    s = '0;
    s.func = FUNC_MAP;
    s.map_layer = l;
    s.row = 3'(r);
    s.column = 4'(c);
    s.map_code = code;
    return s;
  endfunction

  function automatic word_t ev(input logic [1:0] kind, input logic [7:0] code, input logic lst);
    return {kind, code, lst};
  endfunction

  function automatic dir_row_t entry(input stim_t s, input logic typed, input int n,
                                     input word_t r0, input word_t r1);
    dir_row_t d;
    d.s = s;
    d.typed = typed;
    d.n = 2'(n);
    d.r0 = r0;
    d.r1 = r1;
    return d;
  endfunction

  // mostly well-formed samples, reports and keymap writes, some noise
  function automatic stim_t rand_word();
    stim_t s;
    int    pick;
    s = stim_t'(STIM_W'($urandom));
    pick = $urandom_range(99);
    if (pick < 38) begin
      s.func = FUNC_LOCAL;
      if ($urandom_range(9) != 0) begin
        s.row = 3'($urandom_range(ROWS - 1));
        s.column = 4'($urandom_range(LOCAL_COLS - 1));
      end
      if (s.row < ROWS && s.column < LOCAL_COLS && $urandom_range(9) < 7)
        s.level = !level_mem[int'(s.row) * LOCAL_COLS + int'(s.column)];
      s.end_of_scan = ($urandom_range(7) == 0);
    end else if (pick < 70) begin
      s.func = FUNC_REMOTE;
      if ($urandom_range(9) != 0) begin
        s.report_byte[REPORT_IGNORE_BIT] = 1'b0;
        s.report_byte[REPORT_PRESS_BIT] = ($urandom_range(3) != 0);
        if ($urandom_range(7) != 0) s.report_byte[5] = 1'b0;
      end
    end else if (pick < 93) begin
      s.func = FUNC_MAP;
      if ($urandom_range(7) != 0) s.row[2] = 1'b0;
      if ($urandom_range(2) == 0) s.map_code[7:4] = 4'hF;
    end else begin
      s.func = FUNC_UNUSED;
    end
    return s;
  endfunction

  task automatic send_word(input stim_t s, input logic keep);
    if ($urandom_range(99) < src_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < src_idle) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_func        <= s.func;
    in_row         <= s.row;
    in_column      <= s.column;
    in_level       <= s.level;
    in_end_of_scan <= s.end_of_scan;
    in_report_byte <= s.report_byte;
    in_map_layer   <= s.map_layer;
    in_map_code    <= s.map_code;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_events(s, keep);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_events.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(input logic idx, input logic [7:0] value);
    drain();
    repeat (SETTLE) @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (idx == REG_BASE) base_code = value;
    else alt_code = value;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata[7:0] !== value)
      report_mismatch("register readback", int'(prdata[7:0]), int'(value));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin
    base_code = BASE_RESET;
    alt_code = ALT_RESET;
    for (int i = 0; i < ROWS * LOCAL_COLS; i++) level_mem[i] = RELEASED;
    remote_valid = 1'b0;
    remote_idx = '0;
    layer_sel = 1'b0;
    pend_valid = 1'b0;
    pend_code = '0;

    dir_tab[0]  = entry(loc(0, 0, PRESSED, 0), 1, 1, ev(EV_PRESS, 8'h00, 1), '0);
    dir_tab[1]  = entry(loc(0, 0, PRESSED, 0), 1, 0, '0, '0);
    dir_tab[2]  = entry(loc(3, 7, PRESSED, 0), 1, 1, ev(EV_PRESS, 8'h37, 1), '0);
    dir_tab[3]  = entry(loc(3, 7, RELEASED, 1), 1, 1, ev(EV_RELEASE, 8'h37, 1), '0);
    // samples outside the matrix, then keymap writes in and out of it
    dir_tab[4]  = entry(loc(7, 15, PRESSED, 1), 1, 0, '0, '0);
    dir_tab[5]  = entry(loc(0, 8, PRESSED, 0), 1, 0, '0, '0);
    dir_tab[6]  = entry(kmap(0, 1, 2, 8'hF1), 1, 0, '0, '0);
    dir_tab[7]  = entry(kmap(1, 7, 15, 8'hFF), 1, 0, '0, '0);
    // layer key press, silent release, switch to layer one at end of scan
    dir_tab[8]  = entry(loc(1, 2, PRESSED, 0), 1, 1, ev(EV_LAYER, 8'hF1, 1), '0);
    dir_tab[9]  = entry(loc(1, 2, RELEASED, 1), 1, 0, '0, '0);
    dir_tab[10] = entry(loc(0, 1, PRESSED, 0), 1, 1, ev(EV_PRESS, 8'h41, 1), '0);
    dir_tab[11] = entry(rep(8'h40), 1, 1, ev(EV_PRESS, 8'h48, 1), '0);
    dir_tab[12] = entry(rep(8'h5F), 1, 2, ev(EV_RELEASE, 8'h48, 0), ev(EV_PRESS, 8'h7F, 1));
    dir_tab[13] = entry(rep(8'h45), 0, 0, '0, '0);
    dir_tab[14] = entry(rep(8'h45), 1, 0, '0, '0);
    dir_tab[15] = entry(rep(8'hFF), 1, 0, '0, '0);
    dir_tab[16] = entry(rep(8'hC5), 1, 0, '0, '0);
    // press bit with an index row past the matrix reads as no key
    dir_tab[17] = entry(rep(8'h7F), 1, 1, ev(EV_RELEASE, 8'h4D, 1), '0);
    dir_tab[18] = entry(rep(8'h00), 1, 0, '0, '0);
    dir_tab[19] = entry('1, 1, 0, '0, '0);
    dir_tab[20] = entry(kmap(1, 0, 9, 8'hF0), 1, 0, '0, '0);
    dir_tab[21] = entry(rep(8'h41), 1, 1, ev(EV_LAYER, 8'hF0, 1), '0);
    dir_tab[22] = entry(rep(8'h01), 0, 0, '0, '0);
    dir_tab[23] = entry(loc(0, 0, RELEASED, 0), 1, 1, ev(EV_RELEASE, 8'h00, 1), '0);
    dir_tab[24] = entry(loc(0, 1, RELEASED, 0), 1, 1, ev(EV_RELEASE, 8'h01, 1), '0);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    src_idle = 38;
    snk_idle = 64;
    // fill both layers so that no unwritten entry is ever read
    for (int l = 0; l < 2; l++) begin
      for (int r = 0; r < ROWS; r++) begin
        for (int c = 0; c < ALL_COLS; c++) begin
          send_word(kmap(1'(l), r, c, 8'(l * 64 + r * 16 + c)), 1'b1);
        end
      end
    end

    for (int i = 0; i < DIR_ROWS; i++) begin
      send_word(dir_tab[i].s, !dir_tab[i].typed);
      if (dir_tab[i].typed) begin
        if (dir_tab[i].n > 0) expected_events.push_back(dir_tab[i].r0);
        if (dir_tab[i].n > 1) expected_events.push_back(dir_tab[i].r1);
      end
    end

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          cfg_write(REG_BASE, 8'hFF);
          cfg_write(REG_ALT, 8'hF0);
        end
        1: begin
          src_idle = 64;
          snk_idle = 38;
          cfg_write(REG_BASE, 8'hF7);
          cfg_write(REG_ALT, 8'hF7);
        end
        default: begin
          src_idle = 0;
          snk_idle = 0;
          cfg_write(REG_BASE, 8'hF0);
          cfg_write(REG_ALT, 8'hFF);
        end
      endcase
      for (int k = 0; k < PHASE_WORDS; k++) begin
        send_word(rand_word(), 1'b1);
        if (ph == 0 && k == PHASE_WORDS / 2) drain();
      end
    end

    drain();
    repeat (SETTLE * 2) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
